[hw/rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache.
`timescale 1ns / 1ps

package lfu_pkg;

  // Default number of entries
  localparam int unsigned ENTRIES_DEF = 16;

  // Word field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned USES_W = 16;

  localparam logic [USES_W-1:0] USES_MAX  = '1;
  localparam logic [USES_W-1:0] USES_ONE  = USES_W'(1);
  localparam logic [DATA_W-1:0] MISS_DATA = '1;

  // Configuration register file
  localparam int unsigned CAP_IN_W  = 5;
  localparam int unsigned CAP_RESET = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_CAPACITY = 1'b0;

  // Operation codes
  typedef enum logic {
    KIND_SET = 1'b0,
    KIND_GET = 1'b1
  } lfu_kind_e;

  // Write enables of the entry store
  typedef struct packed {
    logic key;
    logic data;
    logic uses;
    logic rec;
    logic valid;
  } lfu_wr_t;

endpackage

[hw/rtl/lfu_cfg.sv]
// APB register file holding the cache capacity.
`timescale 1ns / 1ps

module lfu_cfg #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]  paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]  pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         empty_i,
  output logic [CNT_W-1:0]             capacity_o
);
  import lfu_pkg::*;

  localparam int unsigned CapRst = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

  logic [CNT_W-1:0]    cap_q, cap_d;
  logic [CAP_IN_W-1:0] wr_cap;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_cap = pwdata[CAP_IN_W-1:0];
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY) && empty_i;

  // Clamp the written capacity to one through ENTRIES
  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      if (wr_cap == '0) begin
        cap_d = CNT_W'(1);
      end else if (int'(wr_cap) > int'(ENTRIES)) begin
        cap_d = CNT_W'(ENTRIES);
      end else begin
        cap_d = CNT_W'(wr_cap);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(CapRst);
    end else begin
      cap_q <= cap_d;
    end
  end

  // Read back the capacity
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = PDATA_W'(cap_q);
    end
  end

  assign capacity_o = cap_q;

endmodule

[hw/rtl/lfu_store.sv]
// Entry store: key, data, use count and recency memories plus valid bits.
`timescale 1ns / 1ps

module lfu_store #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [IDX_W-1:0]            rd_addr_i,
  output logic                        rd_valid_o,
  output logic [lfu_pkg::KEY_W-1:0]   rd_key_o,
  output logic [lfu_pkg::DATA_W-1:0]  rd_data_o,
  output logic [lfu_pkg::USES_W-1:0]  rd_uses_o,
  output logic [IDX_W-1:0]            rd_rec_o,
  input  lfu_pkg::lfu_wr_t            wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [lfu_pkg::KEY_W-1:0]   wr_key_i,
  input  logic [lfu_pkg::DATA_W-1:0]  wr_data_i,
  input  logic [lfu_pkg::USES_W-1:0]  wr_uses_i,
  input  logic [IDX_W-1:0]            wr_rec_i
);
  import lfu_pkg::*;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [USES_W-1:0] uses_mem [ENTRIES];
  logic [IDX_W-1:0]  rec_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  // Write one entry; fields have their own enables
  always_ff @(posedge clk_i) begin
    if (wr_en_i.key) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_en_i.data) begin
      data_mem[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i.uses) begin
      uses_mem[wr_addr_i] <= wr_uses_i;
    end
    if (wr_en_i.rec) begin
      rec_mem[wr_addr_i] <= wr_rec_i;
    end
  end

  // Registered read of one entry
  always_ff @(posedge clk_i) begin
    rd_key_o  <= key_mem[rd_addr_i];
    rd_data_o <= data_mem[rd_addr_i];
    rd_uses_o <= uses_mem[rd_addr_i];
    rd_rec_o  <= rec_mem[rd_addr_i];
  end

  // Valid bits clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      rd_valid_o <= valid_q[rd_addr_i];
      if (wr_en_i.valid) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lfu_ctrl.sv]
// Sequencer: lookup scan, replacement choice, recency aging pass and entry update.
`timescale 1ns / 1ps

module lfu_ctrl #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int unsigned CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lfu_pkg::lfu_kind_e          kind_i,
  input  logic [lfu_pkg::KEY_W-1:0]   key_i,
  input  logic [lfu_pkg::DATA_W-1:0]  value_i,
  output logic                        result_valid_o,
  output logic                        found_o,
  output logic [lfu_pkg::DATA_W-1:0]  read_value_o,
  input  logic [CNT_W-1:0]            capacity_i,
  output logic [CNT_W-1:0]            filled_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  input  logic                        rd_valid_i,
  input  logic [lfu_pkg::KEY_W-1:0]   rd_key_i,
  input  logic [lfu_pkg::DATA_W-1:0]  rd_data_i,
  input  logic [lfu_pkg::USES_W-1:0]  rd_uses_i,
  input  logic [IDX_W-1:0]            rd_rec_i,
  output lfu_pkg::lfu_wr_t            wr_en_o,
  output logic [IDX_W-1:0]            wr_addr_o,
  output logic [lfu_pkg::KEY_W-1:0]   wr_key_o,
  output logic [lfu_pkg::DATA_W-1:0]  wr_data_o,
  output logic [lfu_pkg::USES_W-1:0]  wr_uses_o,
  output logic [IDX_W-1:0]            wr_rec_o
);
  import lfu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FIND   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_AGE    = 5'b01000,
    S_WRITE  = 5'b10000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Scan counter and the entry whose read word returns this cycle
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             proc_vld_q;
  logic [IDX_W-1:0] proc_idx_q;
  logic             issue, proc_last, accept;

  // Item word
  lfu_kind_e        kind_q;
  logic [KEY_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;

  // Lookup results
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [DATA_W-1:0] hit_data_q, hit_data_d;
  logic [USES_W-1:0] hit_uses_q, hit_uses_d;
  logic [IDX_W-1:0]  hit_rec_q, hit_rec_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              vic_q, vic_d;
  logic [IDX_W-1:0]  vic_idx_q, vic_idx_d;
  logic [USES_W-1:0] vic_uses_q, vic_uses_d;
  logic [IDX_W-1:0]  vic_rec_q, vic_rec_d;

  // Update plan
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  thr_q, thr_d;
  logic              age_all_q, age_all_d;
  logic              fill_q, fill_d;
  logic              new_q, new_d;
  logic [USES_W-1:0] uses_new_q, uses_new_d;

  logic [CNT_W-1:0]  filled_q, filled_d;
  logic              res_vld_q, res_vld_d;
  logic              found_q, found_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              age_hit;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign issue     = ((state_q == S_FIND) || (state_q == S_AGE)) &&
                     (cnt_q < CNT_W'(ENTRIES));
  assign proc_last = proc_vld_q && (proc_idx_q == IDX_W'(ENTRIES - 1));
  assign rd_addr_o = issue ? cnt_q[IDX_W-1:0] : '0;

  // Compare unit of the lookup scan: match, first free entry, eviction candidate
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_data_d = hit_data_q;
    hit_uses_d = hit_uses_q;
    hit_rec_d  = hit_rec_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    vic_d      = vic_q;
    vic_idx_d  = vic_idx_q;
    vic_uses_d = vic_uses_q;
    vic_rec_d  = vic_rec_q;
    if (accept) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      vic_d  = 1'b0;
    end else if ((state_q == S_FIND) && proc_vld_q) begin
      if (rd_valid_i && (rd_key_i == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = proc_idx_q;
        hit_data_d = rd_data_i;
        hit_uses_d = rd_uses_i;
        hit_rec_d  = rd_rec_i;
      end
      if (!rd_valid_i && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = proc_idx_q;
      end
      // Lowest use count wins; among equal counts the oldest touch
      if (rd_valid_i && (!vic_q || (rd_uses_i < vic_uses_q) ||
                         ((rd_uses_i == vic_uses_q) && (rd_rec_i > vic_rec_q)))) begin
        vic_d      = 1'b1;
        vic_idx_d  = proc_idx_q;
        vic_uses_d = rd_uses_i;
        vic_rec_d  = rd_rec_i;
      end
    end
  end

  // Decide the outcome once the scan is through
  always_comb begin
    slot_d     = slot_q;
    thr_d      = thr_q;
    age_all_d  = age_all_q;
    fill_d     = fill_q;
    new_d      = new_q;
    uses_new_d = uses_new_q;
    res_vld_d  = 1'b0;
    found_d    = found_q;
    res_data_d = res_data_q;
    if (state_q == S_DECIDE) begin
      if (kind_q == KIND_GET) begin
        res_vld_d  = 1'b1;
        found_d    = hit_q;
        res_data_d = hit_q ? hit_data_q : MISS_DATA;
      end
      age_all_d = 1'b0;
      fill_d    = 1'b0;
      new_d     = 1'b0;
      if (hit_q) begin
        slot_d     = hit_idx_q;
        thr_d      = hit_rec_q;
        uses_new_d = (hit_uses_q == USES_MAX) ? USES_MAX : hit_uses_q + USES_ONE;
      end else if (filled_q < capacity_i) begin
        slot_d     = free_idx_q;
        age_all_d  = 1'b1;
        fill_d     = 1'b1;
        new_d      = 1'b1;
        uses_new_d = USES_ONE;
      end else begin
        slot_d     = vic_idx_q;
        thr_d      = vic_rec_q;
        new_d      = 1'b1;
        uses_new_d = USES_ONE;
      end
    end
  end

  // Age entries touched more recently than the slot, or all others on a fill
  assign age_hit = (state_q == S_AGE) && proc_vld_q && rd_valid_i &&
                   (proc_idx_q != slot_q) && (age_all_q || (rd_rec_i < thr_q));

  // Drive the store write port
  always_comb begin
    wr_en_o   = '0;
    wr_addr_o = slot_q;
    wr_key_o  = key_q;
    wr_data_o = value_q;
    wr_uses_o = uses_new_q;
    wr_rec_o  = '0;
    if (age_hit) begin
      wr_en_o.rec = 1'b1;
      wr_addr_o   = proc_idx_q;
      wr_rec_o    = rd_rec_i + IDX_W'(1);
    end else if (state_q == S_WRITE) begin
      wr_en_o.key   = new_q;
      wr_en_o.data  = (kind_q == KIND_SET);
      wr_en_o.uses  = 1'b1;
      wr_en_o.rec   = 1'b1;
      wr_en_o.valid = fill_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = issue ? cnt_q + CNT_W'(1) : cnt_q;
    filled_d = filled_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FIND;
          cnt_d   = '0;
        end
      end
      S_FIND: begin
        if (proc_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_d = '0;
        if ((kind_q == KIND_GET) && !hit_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_AGE;
        end
      end
      S_AGE: begin
        if (proc_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = S_IDLE;
        if (fill_q) begin
          filled_d = filled_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      proc_vld_q <= 1'b0;
      filled_q   <= '0;
      res_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      vic_q      <= 1'b0;
      age_all_q  <= 1'b0;
      fill_q     <= 1'b0;
      new_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      proc_vld_q <= issue;
      filled_q   <= filled_d;
      res_vld_q  <= res_vld_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      vic_q      <= vic_d;
      age_all_q  <= age_all_d;
      fill_q     <= fill_d;
      new_q      <= new_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    proc_idx_q <= cnt_q[IDX_W-1:0];
    if (accept) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    hit_uses_q <= hit_uses_d;
    hit_rec_q  <= hit_rec_d;
    free_idx_q <= free_idx_d;
    vic_idx_q  <= vic_idx_d;
    vic_uses_q <= vic_uses_d;
    vic_rec_q  <= vic_rec_d;
    slot_q     <= slot_d;
    thr_q      <= thr_d;
    uses_new_q <= uses_new_d;
    found_q    <= found_d;
    res_data_q <= res_data_d;
  end

  assign result_valid_o = res_vld_q;
  assign found_o        = found_q;
  assign read_value_o   = res_data_q;
  assign filled_o       = filled_q;

endmodule

[hw/rtl/lfu_cache.sv]
// LFU cache top level: one entry read per cycle through a scan sequencer.
// A get result strobes for one cycle, registered from the decide state once the lookup scan is through.
// Busy: a get miss through the lookup scan and decide state; a set or get hit also through the aging scan and write.
// Throughput: one item per busy period, set by the single read port of the entry store.
// Reset: valid bits and fill count clear at once, capacity returns to min(16, ENTRIES).
// The receiver cannot stall; each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module lfu_cache #(
  parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic signed [lfu_pkg::KEY_W-1:0]   key_i,
  input  logic signed [lfu_pkg::DATA_W-1:0]  value_i,
  output logic                               result_valid_o,
  output logic                               found_o,
  output logic signed [lfu_pkg::DATA_W-1:0]  read_value_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]        paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]        pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  filled;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_data;
  logic [USES_W-1:0] rd_uses;
  logic [IDX_W-1:0]  rd_rec;
  lfu_wr_t           wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [DATA_W-1:0] wr_data;
  logic [USES_W-1:0] wr_uses;
  logic [IDX_W-1:0]  wr_rec;
  logic [DATA_W-1:0] read_value;

  lfu_cfg #(
    .ENTRIES (ENTRIES),
    .CNT_W   (CNT_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .empty_i    (filled == '0),
    .capacity_o (capacity)
  );

  lfu_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_valid_o (rd_valid),
    .rd_key_o   (rd_key),
    .rd_data_o  (rd_data),
    .rd_uses_o  (rd_uses),
    .rd_rec_o   (rd_rec),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_data_i  (wr_data),
    .wr_uses_i  (wr_uses),
    .wr_rec_i   (wr_rec)
  );

  lfu_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (lfu_kind_e'(kind_i)),
    .key_i          (key_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .read_value_o   (read_value),
    .capacity_i     (capacity),
    .filled_o       (filled),
    .rd_addr_o      (rd_addr),
    .rd_valid_i     (rd_valid),
    .rd_key_i       (rd_key),
    .rd_data_i      (rd_data),
    .rd_uses_i      (rd_uses),
    .rd_rec_i       (rd_rec),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_key_o       (wr_key),
    .wr_data_o      (wr_data),
    .wr_uses_o      (wr_uses),
    .wr_rec_o       (wr_rec)
  );

  assign read_value_o = read_value;

  // An accepted word keeps the cache busy through its scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("cache not busy after accepting a word");

  // A result never follows another in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // The fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled <= capacity)
    else $error("fill count above capacity");

  // A miss always returns all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (read_value_o == MISS_DATA))
    else $error("miss result is not all ones");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the LFU cache: APB setup, queued command driver, result monitor.
`timescale 1ns / 1ps

module testbench;

  import lfu_pkg::*;

  // Full-size store, as the block is built by default
  localparam int unsigned NUM_ENTRIES = ENTRIES_DEF;
  localparam int unsigned SETTLE_CYC  = 2 * NUM_ENTRIES + 8;
  localparam logic [PADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'h4;
  localparam int unsigned EPISODES   = 26;
  localparam int unsigned EPISODE_SZ = 50;
  localparam int unsigned HOT_HITS   = 50;
  localparam int unsigned POOL_MAX   = NUM_ENTRIES + 4;

  typedef struct {
    lfu_kind_e   kind;
    logic [31:0] key;
    logic [31:0] value;
  } command_t;

  typedef struct {
    logic        found;
    logic [31:0] value;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic kind_i = 1'b0;
  logic signed [KEY_W-1:0]  key_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic busy;
  logic result_valid_o;
  logic found_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  command_t pending_q[$];
  lookup_t  lookup_q[$];

  // Mirror of the entry store
  logic        sl_valid [NUM_ENTRIES] = '{default: 1'b0};
  logic [31:0] sl_key   [NUM_ENTRIES] = '{default: '0};
  logic [31:0] sl_data  [NUM_ENTRIES] = '{default: '0};
  logic [15:0] sl_uses  [NUM_ENTRIES] = '{default: '0};
  logic [15:0] sl_rank  [NUM_ENTRIES] = '{default: '0};
  int unsigned filled = 0;
  int unsigned cap = (NUM_ENTRIES < CAP_RESET) ? NUM_ENTRIES : CAP_RESET;

  int unsigned n_fail = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_hits = 0;
  int unsigned n_evict = 0;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  logic no_gaps = 1'b0;

  lfu_cache #(
    .ENTRIES(NUM_ENTRIES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Make slot s the newest; slots newer than its old rank age by one
  function automatic void age_ranks(int s, bit was_ranked);
    logic [15:0] r;
    r = was_ranked ? sl_rank[s] : 16'hFFFF;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (i != s && sl_valid[i] && sl_rank[i] < r) sl_rank[i] = sl_rank[i] + 16'd1;
    end
    sl_rank[s] = '0;
  endfunction

  function automatic int slot_of(logic [31:0] k);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (sl_valid[i] && sl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void bump_slot(int s);
    if (sl_uses[s] != USES_MAX) sl_uses[s] = sl_uses[s] + 16'd1;
    age_ranks(s, 1'b1);
  endfunction

  // Advance the mirror by one accepted command; queue the lookup result of a get
  function automatic void cache_step(lfu_kind_e kind, logic [31:0] k, logic [31:0] v);
    int s;
    lookup_t res;
    s = slot_of(k);
    if (kind == KIND_GET) begin
      if (s < 0) begin
        res.found = 1'b0;
        res.value = MISS_DATA;
      end else begin
        res.found = 1'b1;
        res.value = sl_data[s];
        bump_slot(s);
        n_hits++;
      end
      lookup_q.insert(lookup_q.size(), res);
    end else if (s >= 0) begin
      sl_data[s] = v;
      bump_slot(s);
    end else begin
      if (filled < cap) begin
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
          if (!sl_valid[i]) s = i;
        end
        age_ranks(s, 1'b0);
        sl_valid[s] = 1'b1;
        filled++;
      end else begin
        // Lowest use count wins, oldest touch among ties
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (sl_valid[i]) begin
            if (s < 0 || sl_uses[i] < sl_uses[s] ||
                (sl_uses[i] == sl_uses[s] && sl_rank[i] > sl_rank[s])) s = i;
          end
        end
        age_ranks(s, 1'b1);
        n_evict++;
      end
      sl_key[s]  = k;
      sl_data[s] = v;
      sl_uses[s] = USES_ONE;
    end
  endfunction

  function automatic void cap_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    int unsigned v;
    v = data[CAP_IN_W-1:0];
    if (addr[PADDR_W-1:2] == REG_CAPACITY && filled == 0) begin
      if (v < 1) cap = 1;
      else if (v > NUM_ENTRIES) cap = NUM_ENTRIES;
      else cap = v;
    end
  endfunction

  // Drive command words from the pending queue, with random gaps or gapless runs between them
  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    command_t nxt;
    int unsigned gap;
    if (!rst_ni) begin
      start    <= 1'b0;
      kind_i   <= KIND_SET;
      key_i    <= '0;
      value_i  <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        cache_step(lfu_kind_e'(kind_i), key_i, value_i);
        n_accepted++;
        if (no_gaps) begin
          gap = 0;
        end else if (calm_left != 0) begin
          gap = 0;
          calm_left--;
        end else if ($urandom_range(0, 15) == 0) begin
          gap = 0;
          calm_left = $urandom_range(10, 40);
        end else begin
          gap = $urandom_range(0, 10);
        end
        if (gap == 0 && pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          kind_i  <= nxt.kind;
          key_i   <= nxt.key;
          value_i <= nxt.value;
        end else begin
          start    <= 1'b0;
          gap_left <= gap;
        end
      end else if (!start) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          kind_i  <= nxt.kind;
          key_i   <= nxt.key;
          value_i <= nxt.value;
          start   <= 1'b1;
        end
      end
    end
  end

  // Check each result word against the oldest pending lookup
  always @(posedge clk_i) begin : p_check
    lookup_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      n_results++;
      if (lookup_q.size() == 0) begin
        $error("unexpected result: found %0b, read_value %h", found_o, read_value_o);
        n_fail++;
      end else begin
        want = lookup_q.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, found_o);
          n_fail++;
        end
        if (read_value_o !== want.value) begin
          $error("read_value: expected %h, actual %h", want.value, read_value_o);
          n_fail++;
        end
      end
    end
  end

  task automatic put_cmd(lfu_kind_e kind, logic [31:0] k, logic [31:0] v);
    command_t c;
    c.kind  = kind;
    c.key   = k;
    c.value = v;
    pending_q.insert(pending_q.size(), c);
  endtask

  // Hold until every command is taken and every lookup returned, then let the block settle
  task automatic wait_idle();
    while (pending_q.size() != 0 || start || lookup_q.size() != 0 || busy !== 1'b0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    cap_write(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : p_stim
    logic [31:0] hot_key;
    logic [31:0] pool [POOL_MAX];
    logic [31:0] k;
    logic [31:0] edge_keys [4];
    int unsigned pool_n;
    lfu_kind_e kd;
    edge_keys[0] = 32'h8000_0000;
    edge_keys[1] = 32'h7FFF_FFFF;
    edge_keys[2] = 32'h0000_0000;
    edge_keys[3] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Capacity writes while empty: zero and oversize values clamp, spare address is ignored
    apb_write(CAP_ADDR, 32'd0);
    put_cmd(KIND_GET, 32'h0, 32'h0);
    put_cmd(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    apb_write(CAP_ADDR, 32'd31);
    apb_write(SPARE_ADDR, 32'd1);
    apb_write(CAP_ADDR, 32'hFFFF_FFE0 | 32'($urandom_range(1, NUM_ENTRIES)));
    apb_write(SPARE_ADDR, 32'd2);

    // Extreme keys and values, replace, miss, eviction with tied counts once capacity fills
    put_cmd(KIND_GET, 32'h8000_0000, 32'h0);
    put_cmd(KIND_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    put_cmd(KIND_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    put_cmd(KIND_SET, 32'h0000_0000, 32'h0000_0000);
    put_cmd(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) put_cmd(KIND_GET, edge_keys[i], 32'h0);
    put_cmd(KIND_SET, 32'hFFFF_FFFF, 32'h1234_5678);
    put_cmd(KIND_GET, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 5; i++) put_cmd(KIND_SET, 32'd100 + i, 32'hA5A5_0000 + i);
    for (int i = 0; i < 5; i++) put_cmd(KIND_GET, 32'd100 + i, 32'h0);
    put_cmd(KIND_GET, 32'h7FFF_FFFE, 32'h0);
    wait_idle();

    // The cache is no longer empty, so this write must not take
    apb_write(CAP_ADDR, 32'($urandom_range(0, 31)));

    // Hit one key many times back to back, then evict around it
    hot_key = $urandom;
    no_gaps <= 1'b1;
    put_cmd(KIND_SET, hot_key, $urandom);
    for (int i = 0; i < HOT_HITS; i++) begin
      kd = lfu_kind_e'($urandom_range(0, 1));
      put_cmd(kd, hot_key, $urandom);
    end
    for (int i = 0; i <= int'(cap); i++) put_cmd(KIND_SET, $urandom, $urandom);
    put_cmd(KIND_GET, hot_key, 32'h0);
    wait_idle();
    no_gaps <= 1'b0;

    // Random traffic: mostly a small key pool per episode, some stray keys
    for (int ep = 0; ep < EPISODES; ep++) begin
      pool_n = cap + $urandom_range(0, 3);
      for (int p = 0; p < pool_n; p++) begin
        pool[p] = ($urandom_range(0, 7) == 0) ? edge_keys[$urandom_range(0, 3)] : $urandom;
      end
      for (int n = 0; n < EPISODE_SZ; n++) begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = pool[$urandom_range(0, pool_n - 1)];
        kd = lfu_kind_e'($urandom_range(0, 1));
        put_cmd(kd, k, $urandom);
      end
      if (ep == EPISODES / 2) begin
        wait_idle();
        apb_write(CAP_ADDR, 32'($urandom_range(0, 31)));
        apb_write(SPARE_ADDR, $urandom);
      end
    end
    wait_idle();

    $display("%0d commands accepted, %0d lookups checked (%0d hits), %0d evictions, capacity %0d",
             n_accepted, n_results, n_hits, n_evict, cap);
    if (n_fail == 0 && lookup_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cfg.sv
hw/rtl/lfu_store.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_cache.sv
verif/testbench.sv
